// File: hw/rtl/ith_pkg.sv
// Shared constants and types for the ignition tachometer and hour meter.
package ith_pkg;

  // Width of timer counts, periods and the speed quotient.
  localparam int DIV_W = 32;
  // Iteration counter width: it must hold DIV_W itself.
  localparam int CNT_W = $clog2(DIV_W + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_PERIOD     = 2'd0;
  localparam logic [1:0] REG_RPM_SCALE      = 2'd1;
  localparam logic [1:0] REG_REVS_PER_PULSE = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd3;

  // Reset values.
  localparam logic [31:0] MIN_PERIOD_RST     = 32'd1;
  localparam logic [31:0] RPM_SCALE_RST      = 32'd960000000;
  localparam logic [7:0]  REVS_PER_PULSE_RST = 8'd1;
  localparam logic [31:0] TIMEOUT_TICKS_RST  = 32'd1000000;
  localparam logic [31:0] PERIOD_RST         = 32'd48000;

  // Input item modes.
  localparam logic MODE_CAPTURE = 1'b0;
  localparam logic MODE_POLL    = 1'b1;

  // Status the divider reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } ith_div_sts_t;

endpackage

// File: hw/rtl/ith_div.sv
// Iterative restoring divider: one quotient bit per cycle.
module ith_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ith_pkg::DIV_W-1:0]  dividend,
  input  logic [ith_pkg::DIV_W-1:0]  divisor,
  output logic [ith_pkg::DIV_W-1:0]  quotient,
  output ith_pkg::ith_div_sts_t      sts
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [ith_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ith_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [ith_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [ith_pkg::DIV_W-1:0] dsr_r, dsr_nxt;

  logic [ith_pkg::DIV_W:0]   rem_sh;
  logic [ith_pkg::DIV_W:0]   rem_sub;
  logic                      ge;

  // One shift-and-subtract step. A zero divisor always passes the compare,
  // so the quotient comes out as all ones.
  always_comb begin
    rem_sh  = {rem_r, quo_r[ith_pkg::DIV_W-1]};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_sub = rem_sh - {1'b0, dsr_r};
  end

  // Iteration control.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ith_pkg::CNT_W'(ith_pkg::DIV_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[ith_pkg::DIV_W-1:0] : rem_sh[ith_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[ith_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ith_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state resets; the datapath does not need to.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  // A new division is never started on top of one in flight.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

  // Done follows the last iteration exactly.
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == ith_pkg::CNT_W'(1)) |=> (done_r && !busy_r))
    else $error("divider done pulse missing");

endmodule

// File: hw/rtl/ignition_tachometer_hour_meter_top.sv
// Top level of the ignition tachometer with hour meter and revolution counter.
//
// Each input beat is either an ignition capture (mode 0) or a timeout poll
// (mode 1) carrying the free-running timer count, and each one yields
// exactly one output beat with the speed, period, running flag, both 64-bit
// totals and the save request as they stand after that beat. A capture
// whose period is accepted runs the 32-bit restoring divider (one quotient
// bit per cycle) via the evaluate, divide and publish states; other beats
// go from evaluate to publish. The block takes one beat at a time and holds
// in_stall high while it works. A finished result waits in the output
// register, and the block already accepts the next input beat then. The
// user must write configuration through cfg_we/cfg_index/cfg_wdata only
// while the block is idle; the block itself does not enforce this.
module ignition_tachometer_hour_meter_top (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_timer_count,
  // Output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rpm_x16,
  output logic [31:0] out_period_ticks,
  output logic        out_motor_on,
  output logic [63:0] out_run_ticks,
  output logic [63:0] out_revolutions,
  output logic        out_save_request
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_PUB  = 2'd3;

  logic [1:0]  state_r, state_nxt;

  // Configuration registers.
  logic [31:0] min_period_r;
  logic [31:0] rpm_scale_r;
  logic [7:0]  revs_per_pulse_r;
  logic [31:0] timeout_ticks_r;

  // Engine state.
  logic        armed_r, armed_nxt;
  logic [31:0] last_capture_r, last_capture_nxt;
  logic [31:0] period_r, period_nxt;
  logic [31:0] speed_r, speed_nxt;
  logic        running_r, running_nxt;
  logic [63:0] tick_total_r, tick_total_nxt;
  logic [63:0] rev_total_r, rev_total_nxt;
  logic        save_r, save_nxt;

  // Held input beat.
  logic        mode_r;
  logic [31:0] count_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_rpm_r;
  logic [31:0] out_period_r;
  logic        out_running_r;
  logic [63:0] out_ticks_r;
  logic [63:0] out_revs_r;
  logic        out_save_r;

  logic        in_acc;
  logic        out_load;
  logic [31:0] diff;
  logic        div_start;
  logic [31:0] div_q;
  ith_pkg::ith_div_sts_t div_sts;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_PUB) && (!out_valid_r || !out_stall);
  assign diff     = count_r - last_capture_r;

  // Divider for the speed: rpm_scale / period.
  ith_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rpm_scale_r),
    .divisor  (diff),
    .quotient (div_q),
    .sts      (div_sts)
  );

  // Sequencer and state update.
  always_comb begin
    state_nxt        = state_r;
    armed_nxt        = armed_r;
    last_capture_nxt = last_capture_r;
    period_nxt       = period_r;
    speed_nxt        = speed_r;
    running_nxt      = running_r;
    tick_total_nxt   = tick_total_r;
    rev_total_nxt    = rev_total_r;
    save_nxt         = save_r;
    div_start        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          save_nxt  = 1'b0;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_PUB;
        if (mode_r == ith_pkg::MODE_CAPTURE) begin
          if (!armed_r) begin
            // First capture only arms.
            armed_nxt        = 1'b1;
            last_capture_nxt = count_r;
          end else if (diff >= min_period_r) begin
            last_capture_nxt = count_r;
            period_nxt       = diff;
            tick_total_nxt   = tick_total_r + 64'(diff);
            rev_total_nxt    = rev_total_r + 64'(revs_per_pulse_r);
            running_nxt      = 1'b1;
            div_start        = 1'b1;
            state_nxt        = S_DIV;
          end
        end else if (running_r && (diff > timeout_ticks_r)) begin
          // Timeout: count the last period and stop the engine.
          tick_total_nxt = tick_total_r + 64'(period_r);
          speed_nxt      = '0;
          period_nxt     = '0;
          running_nxt    = 1'b0;
          armed_nxt      = 1'b0;
          save_nxt       = 1'b1;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          speed_nxt = div_q;
          state_nxt = S_PUB;
        end
      end
      S_PUB: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // Output beat is held until the consumer takes it.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      min_period_r     <= ith_pkg::MIN_PERIOD_RST;
      rpm_scale_r      <= ith_pkg::RPM_SCALE_RST;
      revs_per_pulse_r <= ith_pkg::REVS_PER_PULSE_RST;
      timeout_ticks_r  <= ith_pkg::TIMEOUT_TICKS_RST;
      armed_r          <= 1'b0;
      last_capture_r   <= '0;
      period_r         <= ith_pkg::PERIOD_RST;
      speed_r          <= '0;
      running_r        <= 1'b0;
      tick_total_r     <= '0;
      rev_total_r      <= '0;
      save_r           <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      armed_r        <= armed_nxt;
      last_capture_r <= last_capture_nxt;
      period_r       <= period_nxt;
      speed_r        <= speed_nxt;
      running_r      <= running_nxt;
      tick_total_r   <= tick_total_nxt;
      rev_total_r    <= rev_total_nxt;
      save_r         <= save_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ith_pkg::REG_MIN_PERIOD:     min_period_r     <= cfg_wdata;
          ith_pkg::REG_RPM_SCALE:      rpm_scale_r      <= cfg_wdata;
          ith_pkg::REG_REVS_PER_PULSE: revs_per_pulse_r <= cfg_wdata[7:0];
          ith_pkg::REG_TIMEOUT_TICKS:  timeout_ticks_r  <= cfg_wdata;
        endcase
      end
    end
  end

  // Payload registers: input beat capture and output snapshot.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_mode;
      count_r <= in_timer_count;
    end
    if (out_load) begin
      out_rpm_r     <= speed_r;
      out_period_r  <= period_r;
      out_running_r <= running_r;
      out_ticks_r   <= tick_total_r;
      out_revs_r    <= rev_total_r;
      out_save_r    <= save_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rpm_x16      = out_rpm_r;
  assign out_period_ticks = out_period_r;
  assign out_motor_on     = out_running_r;
  assign out_run_ticks    = out_ticks_r;
  assign out_revolutions  = out_revs_r;
  assign out_save_request = out_save_r;

  // The engine can only run while armed.
  a_running_armed: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> armed_r)
    else $error("running without armed");

  // A stopped engine never reports a speed.
  a_stopped_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_running_r) |-> (out_rpm_r == '0))
    else $error("speed shown while stopped");

  // A save request comes only with a cleared speed and period.
  a_save_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_save_r) |-> (!out_running_r && out_period_r == '0 &&
                                     out_rpm_r == '0))
    else $error("save request with engine state not cleared");

  // The divider only reports completion while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV))
    else $error("divider done outside of the divide state");

endmodule

// File: tb/ith_result_monitor.sv
// Monitor that predicts and checks every result beat of the tachometer block.
module ith_result_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_mode,
  input  logic [31:0] in_timer_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_rpm_x16,
  input  logic [31:0] out_period_ticks,
  input  logic        out_motor_on,
  input  logic [63:0] out_run_ticks,
  input  logic [63:0] out_revolutions,
  input  logic        out_save_request,
  output int          fail_count,
  output int          pending_count
);

  // One result beat as the block reports it.
  typedef struct packed {
    logic [31:0] rpm_x16;
    logic [31:0] period_ticks;
    logic        motor_on;
    logic [63:0] run_ticks;
    logic [63:0] revolutions;
    logic        save_request;
  } tach_reading_t;

  // Mirrored configuration registers.
  logic [31:0] min_period_q;
  logic [31:0] rpm_scale_q;
  logic [7:0]  revs_per_pulse_q;
  logic [31:0] timeout_q;

  // Mirrored engine state.
  logic        is_armed;
  logic [31:0] prev_capture;
  logic [31:0] cur_period;
  logic [31:0] cur_speed;
  logic        is_running;
  logic [63:0] tick_sum;
  logic [63:0] rev_sum;

  // Readings that the block still owes, oldest first.
  tach_reading_t readings_due[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Advance the engine state by one input beat and form the reading it yields.
  task automatic update_engine(input logic mode, input logic [31:0] count,
                               output tach_reading_t reading);
    logic [31:0] delta;
    logic        stopped;
    delta   = count - prev_capture;
    stopped = 1'b0;
    if (mode == ith_pkg::MODE_CAPTURE) begin
      if (!is_armed) begin
        is_armed     = 1'b1;
        prev_capture = count;
      end else if (delta >= min_period_q) begin
        prev_capture = count;
        cur_period   = delta;
        // A zero period saturates the speed.
        cur_speed    = (delta == 32'd0) ? 32'hFFFF_FFFF : rpm_scale_q / delta;
        tick_sum     = tick_sum + {32'd0, delta};
        rev_sum      = rev_sum + {56'd0, revs_per_pulse_q};
        is_running   = 1'b1;
      end
    end else if (is_running && delta > timeout_q) begin
      // The engine stopped: book the last period and ask for a save.
      tick_sum   = tick_sum + {32'd0, cur_period};
      cur_speed  = 32'd0;
      cur_period = 32'd0;
      is_running = 1'b0;
      is_armed   = 1'b0;
      stopped    = 1'b1;
    end
    reading.rpm_x16      = cur_speed;
    reading.period_ticks = cur_period;
    reading.motor_on     = is_running;
    reading.run_ticks    = tick_sum;
    reading.revolutions  = rev_sum;
    reading.save_request = stopped;
  endtask

  // Compare one field and count a mismatch.
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Sample the channels at each rising edge: results first, then new beats.
  always @(posedge clk) begin
    tach_reading_t want;
    tach_reading_t fresh;
    if (!rst_n) begin
      min_period_q     = ith_pkg::MIN_PERIOD_RST;
      rpm_scale_q      = ith_pkg::RPM_SCALE_RST;
      revs_per_pulse_q = ith_pkg::REVS_PER_PULSE_RST;
      timeout_q        = ith_pkg::TIMEOUT_TICKS_RST;
      is_armed         = 1'b0;
      prev_capture     = 32'd0;
      cur_period       = ith_pkg::PERIOD_RST;
      cur_speed        = 32'd0;
      is_running       = 1'b0;
      tick_sum         = 64'd0;
      rev_sum          = 64'd0;
      readings_due.delete();
    end else begin
      // Check an accepted result beat against the oldest expectation.
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count++;
        end else begin
          want = readings_due.pop_front();
          check_field("rpm_x16", {32'd0, want.rpm_x16}, {32'd0, out_rpm_x16});
          check_field("period_ticks", {32'd0, want.period_ticks},
                      {32'd0, out_period_ticks});
          check_field("motor_on", {63'd0, want.motor_on},
                      {63'd0, out_motor_on});
          check_field("run_ticks", want.run_ticks, out_run_ticks);
          check_field("revolutions", want.revolutions, out_revolutions);
          check_field("save_request", {63'd0, want.save_request},
                      {63'd0, out_save_request});
        end
      end
      // Track register writes.
      if (cfg_we) begin
        case (cfg_index)
          ith_pkg::REG_MIN_PERIOD:     min_period_q     = cfg_wdata;
          ith_pkg::REG_RPM_SCALE:      rpm_scale_q      = cfg_wdata;
          ith_pkg::REG_REVS_PER_PULSE: revs_per_pulse_q = cfg_wdata[7:0];
          ith_pkg::REG_TIMEOUT_TICKS:  timeout_q        = cfg_wdata;
          default: ;
        endcase
      end
      // Predict the result of an accepted input beat.
      if (in_valid && !in_stall) begin
        update_engine(in_mode, in_timer_count, fresh);
        readings_due.push_back(fresh);
      end
    end
    pending_count = readings_due.size();
  end

endmodule

// File: tb/ignition_tachometer_hour_meter_top_test.sv
// Stimulus, clock, reset and verdict for the tachometer and hour meter block.
module ignition_tachometer_hour_meter_top_test;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [31:0] in_timer_count;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_rpm_x16;
  logic [31:0] out_period_ticks;
  logic        out_motor_on;
  logic [63:0] out_run_ticks;
  logic [63:0] out_revolutions;
  logic        out_save_request;
  int          fail_count;
  int          pending_count;

  // Local copy of the settings that shape the timer gaps.
  logic [31:0] gap_min;
  logic [31:0] gap_timeout;
  // Free-running timer as the stimulus sees it.
  logic [31:0] timer_now;
  // Sender burst bookkeeping and the no-idle switches for both sides.
  int          burst_left;
  bit          tx_steady;
  bit          rx_steady;
  int          cycle_count;

  ignition_tachometer_hour_meter_top dut (.*);
  ith_result_monitor mon (.*);

  always #4 clk = ~clk;

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stalls in runs of random length, alternating with free runs.
  int  stall_left = 0;
  bit  stall_run  = 1'b0;
  always @(negedge clk) begin
    if (!rst_n || rx_steady) begin
      out_stall = 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_run  = ~stall_run;
        stall_left = stall_run ? (($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
                                                               : $urandom_range(1, 6))
                               : $urandom_range(1, 30);
      end
      stall_left--;
      out_stall = stall_run;
    end
  end

  // Write one register; called at a falling edge while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == ith_pkg::REG_MIN_PERIOD)    gap_min     = value;
    if (idx == ith_pkg::REG_TIMEOUT_TICKS) gap_timeout = value;
  endtask

  // Write the whole register set.
  task automatic load_settings(input logic [31:0] min_p, input logic [31:0] scale,
                               input logic [7:0] revs, input logic [31:0] tmo);
    write_reg(ith_pkg::REG_MIN_PERIOD, min_p);
    write_reg(ith_pkg::REG_RPM_SCALE, scale);
    write_reg(ith_pkg::REG_REVS_PER_PULSE, {24'd0, revs});
    write_reg(ith_pkg::REG_TIMEOUT_TICKS, tmo);
  endtask

  // Offer one beat, idling between bursts, and return after its acceptance.
  task automatic send_beat(input logic mode, input logic [31:0] count);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (!tx_steady) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       = 1'b1;
    in_mode        = mode;
    in_timer_count = count;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Let every owed result arrive, then a few spare cycles.
  task automatic settle();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Gap between captures: mostly plausible periods, some short, some wild.
  function automatic logic [31:0] capture_gap();
    logic [63:0] span;
    int          pick;
    pick = $urandom_range(0, 99);
    span = (gap_min < 32'd100000) ? {32'd0, gap_min} * 3 + 64'd2000 : 64'd2000;
    if (pick < 60) return gap_min + $urandom_range(0, span[31:0]);
    if (pick < 75) return (gap_min == 32'd0) ? 32'd0 : $urandom_range(0, gap_min - 1);
    if (pick < 85) return $urandom;
    return gap_min;
  endfunction

  // Gap to a poll: just past the timeout, within it, or anything.
  function automatic logic [31:0] poll_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return gap_timeout + $urandom_range(1, 100);
    if (pick < 80) return $urandom_range(0, gap_timeout);
    return $urandom;
  endfunction

  // Random beats: pulse trains with polls, plus some noise.
  task automatic run_random(input int beats);
    int          pick;
    logic [31:0] at;
    for (int i = 0; i < beats; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_beat(1'($urandom_range(0, 1)), $urandom);
      end else if (pick < 70) begin
        timer_now = timer_now + capture_gap();
        send_beat(ith_pkg::MODE_CAPTURE, timer_now);
      end else begin
        at = timer_now + poll_gap();
        send_beat(ith_pkg::MODE_POLL, at);
        if ($urandom_range(0, 1) == 1) timer_now = at;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = ith_pkg::REG_MIN_PERIOD;
    cfg_wdata      = 32'd0;
    in_valid       = 1'b0;
    in_mode        = ith_pkg::MODE_CAPTURE;
    in_timer_count = 32'd0;
    gap_min        = ith_pkg::MIN_PERIOD_RST;
    gap_timeout    = ith_pkg::TIMEOUT_TICKS_RST;
    timer_now      = 32'd0;
    burst_left     = 0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings: poll while stopped, arming, normal pulses, a poll within
    // the timeout, timeout, poll after the stop, re-arming, a period across the
    // timer wrap and a short period.
    send_beat(ith_pkg::MODE_POLL, 32'd0);
    send_beat(ith_pkg::MODE_CAPTURE, 32'd0);
    send_beat(ith_pkg::MODE_CAPTURE, 32'd48000);
    send_beat(ith_pkg::MODE_CAPTURE, 32'd48100);
    send_beat(ith_pkg::MODE_POLL, 32'd548100);
    send_beat(ith_pkg::MODE_POLL, 32'd1048101);
    send_beat(ith_pkg::MODE_POLL, 32'hFFFF_FFFF);
    send_beat(ith_pkg::MODE_CAPTURE, 32'hFFFF_FFFF);
    send_beat(ith_pkg::MODE_CAPTURE, 32'h0000_000F);
    send_beat(ith_pkg::MODE_CAPTURE, 32'h0000_000F);
    settle();

    // Low extremes: zero period gives a saturated speed, zero timeout.
    load_settings(32'd0, 32'hFFFF_FFFF, 8'hFF, 32'd0);
    send_beat(ith_pkg::MODE_CAPTURE, 32'h0000_000F);
    send_beat(ith_pkg::MODE_CAPTURE, 32'h0000_0010);
    send_beat(ith_pkg::MODE_POLL, 32'h0000_0010);
    send_beat(ith_pkg::MODE_POLL, 32'h0000_0011);
    send_beat(ith_pkg::MODE_CAPTURE, 32'h8000_0000);
    send_beat(ith_pkg::MODE_CAPTURE, 32'hFFFF_FFFF);
    settle();

    // High extremes: only the longest period passes, no timeout ever.
    load_settings(32'hFFFF_FFFF, 32'd0, 8'd0, 32'hFFFF_FFFF);
    send_beat(ith_pkg::MODE_CAPTURE, 32'hFFFF_FFFF);
    send_beat(ith_pkg::MODE_CAPTURE, 32'hFFFF_FFFE);
    send_beat(ith_pkg::MODE_POLL, 32'hFFFF_FFFD);
    send_beat(ith_pkg::MODE_POLL, 32'h1234_5678);
    send_beat(ith_pkg::MODE_CAPTURE, 32'd0);
    settle();

    // Random phases over a spread of settings.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: load_settings(ith_pkg::MIN_PERIOD_RST, ith_pkg::RPM_SCALE_RST,
                         ith_pkg::REVS_PER_PULSE_RST, ith_pkg::TIMEOUT_TICKS_RST);
        1: load_settings(32'd0, 32'hFFFF_FFFF, 8'hFF, 32'd0);
        2: load_settings(32'hFFFF_FFFF, 32'd0, 8'd0, 32'hFFFF_FFFF);
        3: load_settings(32'd16, ith_pkg::RPM_SCALE_RST, 8'd2, 32'd50000);
        default: load_settings($urandom_range(0, 5000), $urandom,
                               8'($urandom_range(0, 255)),
                               $urandom_range(1000, 200000));
      endcase
      tx_steady = (phase == 3) || ($urandom_range(0, 3) == 0);
      rx_steady = (phase == 3) || ($urandom_range(0, 3) == 0);
      run_random(phase < 3 ? 60 : 100);
      settle();
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end

    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
